// ===== hdl/sha256c4_pkg.sv =====
// types, constants and round functions for the four-lane sha-256 compression core
// no dependencies; imported by sha256_compress_four_lane_core
package sha256c4_pkg;

   // number of lanes carried on the request and response ports
   localparam int IO_LANES = 4;

   // request function codes
   localparam logic FUNC_CHAIN = 1'b0;
   localparam logic FUNC_MSG   = 1'b1;

   // last message word index, which starts a compression
   localparam logic [3:0] MSG_LAST_INDEX = 4'd15;

   typedef struct packed {
      logic        func;
      logic [3:0]  word_index;
      logic [31:0] lane0_word;
      logic [31:0] lane1_word;
      logic [31:0] lane2_word;
      logic [31:0] lane3_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  digest_index;
      logic [31:0] lane0_digest;
      logic [31:0] lane1_digest;
      logic [31:0] lane2_digest;
      logic [31:0] lane3_digest;
      logic        last_word;
   } rsp_type;

   // big sigma 0 of the round function
   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   // big sigma 1 of the round function
   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   // small sigma 0 of the message schedule
   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   // small sigma 1 of the message schedule
   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   // round constants
   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      case (t)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/sha256_compress_four_lane_core.sv =====
// four-lane sha-256 compression core: chaining state, message store, round unit per lane
// depends on sha256c4_pkg for request/response types and round functions
//
// Usage: a request is taken on a rising edge with start high and busy low.
// A request with func FUNC_CHAIN writes chaining word word_index (0..7) of every
// lane and gives no response; indexes 8..15 are dropped. A request with func
// FUNC_MSG stores message word word_index of every lane; word 15 also starts a
// compression and raises busy.
// A compression loads the round registers from the message store and chaining
// words, runs 64 rounds at one round per cycle in each lane's round unit
// (message schedule built on the fly in a 16-word sliding window), then adds
// the round variables into the chaining words. After that, eight responses follow on
// consecutive cycles, each marked by rsp_valid for one cycle, digest_index
// 0..7, last_word on index 7. busy drops after the eighth response is
// registered, so after word 15 a new request waits for busy to drop; after any
// other request the next one can be taken in the following cycle. The
// receiver cannot stall; each response is taken in the cycle it is shown. Reset
// clears the sequencer and the response strobe; chaining words must be loaded
// before the first compression.
module sha256_compress_four_lane_core #(
   parameter int LANES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sha256c4_pkg::req_type req_data,
   output logic                  rsp_valid,
   output sha256c4_pkg::rsp_type rsp_data
);
   import sha256c4_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] EMIT_LAST  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        accept;
   logic        load_chain;
   logic        load_msg;
   logic [31:0] in_words [IO_LANES];
   logic [31:0] out_words [IO_LANES];

   // per-lane storage
   logic [31:0] chain_ff [LANES][8];
   logic [31:0] msg_ff   [LANES][16];
   logic [31:0] win_ff   [LANES][16];
   logic [31:0] var_ff   [LANES][8];

   assign accept     = start && (state_ff == ST_IDLE);
   assign load_chain = accept && (req_data.func == FUNC_CHAIN) && !req_data.word_index[3];
   assign load_msg   = accept && (req_data.func == FUNC_MSG);
   assign busy       = (state_ff != ST_IDLE);

   // request words as an array
   always_comb begin
      in_words[0] = req_data.lane0_word;
      in_words[1] = req_data.lane1_word;
      in_words[2] = req_data.lane2_word;
      in_words[3] = req_data.lane3_word;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load_msg && (req_data.word_index == MSG_LAST_INDEX)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
            cnt_in   = '0;
         end
         ST_ROUND: begin
            if (cnt_ff == ROUND_LAST) begin
               state_in = ST_ADD;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         ST_ADD: begin
            state_in = ST_EMIT;
            cnt_in   = '0;
         end
         ST_EMIT: begin
            if (cnt_ff[2:0] == EMIT_LAST) begin
               state_in = ST_IDLE;
            end
            cnt_in = cnt_ff + 6'd1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // per-lane round unit and storage
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [31:0] lane_word;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] w_next;

      if (l < IO_LANES) begin : g_io
         assign lane_word = in_words[l];
      end else begin : g_zero
         assign lane_word = '0;
      end

      // one sha-256 round and one schedule step
      always_comb begin
         t1 = var_ff[l][7] + big_sigma1(var_ff[l][4])
            + ((var_ff[l][4] & var_ff[l][5]) ^ (~var_ff[l][4] & var_ff[l][6]))
            + round_k(cnt_ff) + win_ff[l][0];
         t2 = big_sigma0(var_ff[l][0])
            + ((var_ff[l][0] & var_ff[l][1]) ^ (var_ff[l][0] & var_ff[l][2])
               ^ (var_ff[l][1] & var_ff[l][2]));
         w_next = small_sigma1(win_ff[l][14]) + win_ff[l][9]
                + small_sigma0(win_ff[l][1]) + win_ff[l][0];
      end

      always_ff @(posedge clock) begin
         case (state_ff)
            ST_IDLE: begin
               if (load_chain) begin
                  chain_ff[l][req_data.word_index[2:0]] <= lane_word;
               end
               if (load_msg) begin
                  msg_ff[l][req_data.word_index] <= lane_word;
               end
            end
            ST_LOAD: begin
               for (int j = 0; j < 16; j++) begin
                  win_ff[l][j] <= msg_ff[l][j];
               end
               for (int j = 0; j < 8; j++) begin
                  var_ff[l][j] <= chain_ff[l][j];
               end
            end
            ST_ROUND: begin
               // shift the schedule window and the round variables
               for (int j = 0; j < 15; j++) begin
                  win_ff[l][j] <= win_ff[l][j+1];
               end
               win_ff[l][15] <= w_next;
               var_ff[l][7]  <= var_ff[l][6];
               var_ff[l][6]  <= var_ff[l][5];
               var_ff[l][5]  <= var_ff[l][4];
               var_ff[l][4]  <= var_ff[l][3] + t1;
               var_ff[l][3]  <= var_ff[l][2];
               var_ff[l][2]  <= var_ff[l][1];
               var_ff[l][1]  <= var_ff[l][0];
               var_ff[l][0]  <= t1 + t2;
            end
            ST_ADD: begin
               for (int j = 0; j < 8; j++) begin
                  chain_ff[l][j] <= chain_ff[l][j] + var_ff[l][j];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // response words per port lane
   for (genvar i = 0; i < IO_LANES; i++) begin : g_out
      if (i < LANES) begin : g_used
         assign out_words[i] = chain_ff[i][cnt_ff[2:0]];
      end else begin : g_none
         assign out_words[i] = '0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in             = (state_ff == ST_EMIT);
      rsp_data_in.digest_index = cnt_ff[2:0];
      rsp_data_in.lane0_digest = out_words[0];
      rsp_data_in.lane1_digest = out_words[1];
      rsp_data_in.lane2_digest = out_words[2];
      rsp_data_in.lane3_digest = out_words[3];
      rsp_data_in.last_word    = (cnt_ff[2:0] == EMIT_LAST);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/tb.sv =====
// self-checking bench for the four-lane sha-256 compression core
// depends on sha256c4_pkg and sha256_compress_four_lane_core; predicts every digest word
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sha256c4_pkg::*;

   localparam int TOTAL_ITEMS  = 430;
   localparam int QUIET_AFTER  = 380;
   localparam int SETTLE_TICKS = 80;

   // standard initial hash value, used as one lane's chaining words
   localparam logic [31:0] CHAIN_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // round constants
   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // per-lane chaining and message state, queue of digest words still due
   class lane_digest_predictor;
      logic [31:0] chain_words [IO_LANES][8];
      logic [31:0] msg_words [IO_LANES][16];
      rsp_type     digest_queue [$];
      int          mismatch_count = 0;

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      function logic [31:0] rotr(logic [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // 64 rounds per lane, then queue the eight updated chaining words
      function void compress_lanes();
         logic [31:0] w [64];
         logic [31:0] v [8];
         logic [31:0] t1, t2, ch, maj;
         rsp_type     r;
         for (int l = 0; l < IO_LANES; l++) begin
            for (int t = 0; t < 16; t++)
               w[t] = msg_words[l][t];
            for (int t = 16; t < 64; t++)
               w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                    + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            for (int t = 0; t < 8; t++)
               v[t] = chain_words[l][t];
            for (int t = 0; t < 64; t++) begin
               ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
               maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
               t1  = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
                   + ROUND_CONST[t] + w[t];
               t2  = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;
               v[7] = v[6];
               v[6] = v[5];
               v[5] = v[4];
               v[4] = v[3] + t1;
               v[3] = v[2];
               v[2] = v[1];
               v[1] = v[0];
               v[0] = t1 + t2;
            end
            for (int t = 0; t < 8; t++)
               chain_words[l][t] = chain_words[l][t] + v[t];
         end
         for (int k = 0; k < 8; k++) begin
            r.digest_index = 3'(k);
            r.lane0_digest = chain_words[0][k];
            r.lane1_digest = chain_words[1][k];
            r.lane2_digest = chain_words[2][k];
            r.lane3_digest = chain_words[3][k];
            r.last_word    = (k == 7);
            digest_queue.push_back(r);
         end
      endfunction

      // accepted request: chaining load, message store, compression on the last word
      function void note_request(req_type r);
         logic [31:0] words [IO_LANES];
         words = '{r.lane0_word, r.lane1_word, r.lane2_word, r.lane3_word};
         if (r.func == FUNC_CHAIN) begin
            // chaining index above seven is dropped
            if (r.word_index < 4'd8)
               for (int l = 0; l < IO_LANES; l++)
                  chain_words[l][r.word_index[2:0]] = words[l];
            return;
         end
         for (int l = 0; l < IO_LANES; l++)
            msg_words[l][r.word_index] = words[l];
         if (r.word_index == MSG_LAST_INDEX)
            compress_lanes();
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want,
                         logic [2:0] idx);
         if (got !== want)
            report_mismatch($sformatf("word %0d %s got %h want %h", idx, name, got, want));
      endtask

      // accepted response against the oldest digest word due
      task check_digest(rsp_type got);
         rsp_type want;
         if (digest_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %0d", got.digest_index));
            return;
         end
         want = digest_queue.pop_front();
         compare_field("digest_index", 32'(got.digest_index), 32'(want.digest_index),
                       want.digest_index);
         compare_field("lane0", got.lane0_digest, want.lane0_digest, want.digest_index);
         compare_field("lane1", got.lane1_digest, want.lane1_digest, want.digest_index);
         compare_field("lane2", got.lane2_digest, want.lane2_digest, want.digest_index);
         compare_field("lane3", got.lane3_digest, want.lane3_digest, want.digest_index);
         compare_field("last_word", 32'(got.last_word), 32'(want.last_word),
                       want.digest_index);
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   lane_digest_predictor digests = new();
   int sent_items = 0;
   bit allow_idle = 1'b0;
   int order [16];

   sha256_compress_four_lane_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // responses are sampled mid-cycle, away from the driving edge
   always @(negedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         digests.check_digest(rsp_data);
   end

   // lane word with extremes mixed in
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_request(logic func, logic [3:0] idx);
      return req_type'{func, idx, rand_word(), rand_word(), rand_word(), rand_word()};
   endfunction

   // random permutation of 0..n-1 in order
   task automatic shuffle_order(int n);
      int j, tmp;
      for (int i = 0; i < n; i++)
         order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
   endtask

   // present one request until taken, then maybe idle for a burst
   task automatic send_request(input req_type r);
      logic taken;
      start <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end while (!taken);
      digests.note_request(r);
      if (!(r.func == FUNC_CHAIN && r.word_index > 4'd7))
         sent_items++;
      if (allow_idle && sent_items < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // hold off requests until every digest word due has come back
   task automatic wait_for_digests();
      start <= 1'b0;
      do
         @(posedge clock);
      while (digests.digest_queue.size() != 0);
   endtask

   // stimulus
   initial begin
      int kind, n, settle;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: iv, zero, all-ones and random lanes, dropped chaining index, "abc" block
      allow_idle = 1'b1;
      for (int i = 0; i < 8; i++)
         send_request(req_type'{FUNC_CHAIN, 4'(i), CHAIN_IV[i], 32'h0, 32'hffff_ffff,
                                $urandom});
      send_request(req_type'{FUNC_CHAIN, 4'd15, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff});
      for (int i = 0; i < 16; i++)
         send_request(req_type'{FUNC_MSG, 4'(i),
                                (i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h18 : 32'h0,
                                32'h0, 32'hffff_ffff, $urandom});
      wait_for_digests();

      // random sequences, mostly full blocks
      while (sent_items < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 99);
         allow_idle = ($urandom_range(0, 9) < 7);
         if (kind < 55) begin
            // full block in order
            for (int i = 0; i < 16; i++)
               send_request(rand_request(FUNC_MSG, 4'(i)));
         end else if (kind < 67) begin
            // chaining reload in shuffled order
            shuffle_order(8);
            for (int i = 0; i < 8; i++)
               send_request(rand_request(FUNC_CHAIN, 4'(order[i])));
         end else if (kind < 79) begin
            // message words out of order, then the last word
            shuffle_order(15);
            n = $urandom_range(1, 15);
            for (int i = 0; i < n; i++)
               send_request(rand_request(FUNC_MSG, 4'(order[i])));
            send_request(rand_request(FUNC_MSG, MSG_LAST_INDEX));
         end else if (kind < 91) begin
            // broken sequence with dropped chaining indexes mixed in
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 2) == 0)
                  send_request(rand_request(FUNC_CHAIN, 4'($urandom_range(8, 15))));
               else
                  send_request(rand_request(FUNC_MSG, 4'($urandom_range(0, 14))));
            end
         end else if (kind < 96) begin
            // lone last word recompresses the stored block
            send_request(rand_request(FUNC_MSG, MSG_LAST_INDEX));
         end else begin
            wait_for_digests();
         end
      end

      // drain and settle
      start <= 1'b0;
      settle = 0;
      while (digests.digest_queue.size() != 0 && settle < 5000) begin
         @(posedge clock);
         settle++;
      end
      repeat (SETTLE_TICKS) @(posedge clock);
      if (digests.digest_queue.size() != 0)
         digests.report_mismatch($sformatf("%0d digest words never arrived",
                                           digests.digest_queue.size()));
      if (digests.mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sha256c4_pkg.sv
hdl/sha256_compress_four_lane_core.sv
sim/tb.sv
